[hdl/ked_pkg.sv]
// shared types and constants of the key event detector
// no dependencies

package ked_pkg;

    // one-hot phase codes of the key machine
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_DOWNCHK  = 5'b00010,
        PH_HELD     = 5'b00100,
        PH_UPCHK    = 5'b01000,
        PH_RELEASED = 5'b10000
    } ked_phase_t;

    // reported event codes
    typedef enum logic [1:0] {
        EV_DOWN   = 2'd0,
        EV_LONG   = 2'd1,
        EV_UP     = 2'd2,
        EV_DOUBLE = 2'd3
    } ked_code_t;

    // report mask bit positions
    localparam int unsigned MASK_DOWN   = 0;
    localparam int unsigned MASK_LONG   = 1;
    localparam int unsigned MASK_REPEAT = 2;
    localparam int unsigned MASK_UP     = 3;
    localparam int unsigned MASK_DOUBLE = 4;

    // register file layout
    localparam int unsigned APB_ADDR_BITS = 5;
    localparam int unsigned APB_DATA_BITS = 32;

    typedef enum logic [2:0] {
        REG_REPORT_MASK    = 3'd0,
        REG_LONG_HOLD_TIME = 3'd1,
        REG_REPEAT_PERIOD  = 3'd2,
        REG_DOUBLE_GAP_MIN = 3'd3,
        REG_DOUBLE_GAP_MAX = 3'd4,
        REG_TICK_STEP      = 3'd5,
        REG_KEY_NUMBER     = 3'd6
    } ked_reg_idx_t;

    typedef struct packed {
        logic [4:0]  report_mask;
        logic [15:0] long_hold_time;
        logic [15:0] repeat_period;
        logic [15:0] double_gap_min;
        logic [15:0] double_gap_max;
        logic [7:0]  tick_step;
        logic [7:0]  key_number;
    } ked_cfg_t;

    localparam logic [4:0]  RST_REPORT_MASK    = 5'd31;
    localparam logic [15:0] RST_LONG_HOLD_TIME = 16'd1000;
    localparam logic [15:0] RST_REPEAT_PERIOD  = 16'd200;
    localparam logic [15:0] RST_DOUBLE_GAP_MIN = 16'd50;
    localparam logic [15:0] RST_DOUBLE_GAP_MAX = 16'd300;
    localparam logic [7:0]  RST_TICK_STEP      = 8'd10;
    localparam logic [7:0]  RST_KEY_NUMBER     = 8'd0;

    // event found for one accepted sample
    typedef struct packed {
        logic      hit;
        ked_code_t code;
    } ked_event_t;

endpackage

[hdl/ked_if.sv]
// request channels of the key event detector: sample in, event out
// no dependencies

interface ked_in_if;
    logic valid;
    logic ready;
    logic pressed;

    modport source (output valid, output pressed, input ready);
    modport sink   (input valid, input pressed, output ready);
endinterface

interface ked_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic [7:0] key_id;

    modport source (output valid, output event_code, output key_id, input ready);
    modport sink   (input valid, input event_code, input key_id, output ready);
endinterface

[hdl/ked_engine.sv]
// phase machine and saturating counters of the key event detector
// depends on ked_pkg

module ked_engine #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               pressed,
    input  ked_pkg::ked_cfg_t  cfg,
    output ked_pkg::ked_event_t ev
);
    import ked_pkg::*;

    // compare width covers both the counters and the 16-bit settings
    localparam int unsigned CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    ked_phase_t              phase_reg, phase_next;
    logic                    last_level_reg;
    logic [COUNT_BITS-1:0]   hold_reg, hold_next;
    logic [COUNT_BITS-1:0]   repeat_reg, repeat_next;
    logic [COUNT_BITS-1:0]   gap_reg, gap_next;

    logic [COUNT_BITS:0]     step_ext;
    logic [COUNT_BITS:0]     hold_sum, repeat_sum, gap_sum;
    logic [COUNT_BITS-1:0]   hold_sat, repeat_sat, gap_sat;
    logic                    same;

    assign step_ext   = (COUNT_BITS + 1)'(cfg.tick_step);
    assign hold_sum   = {1'b0, hold_reg} + step_ext;
    assign repeat_sum = {1'b0, repeat_reg} + step_ext;
    assign gap_sum    = {1'b0, gap_reg} + step_ext;
    assign hold_sat   = hold_sum[COUNT_BITS]   ? '1 : hold_sum[COUNT_BITS-1:0];
    assign repeat_sat = repeat_sum[COUNT_BITS] ? '1 : repeat_sum[COUNT_BITS-1:0];
    assign gap_sat    = gap_sum[COUNT_BITS]    ? '1 : gap_sum[COUNT_BITS-1:0];
    assign same       = (pressed == last_level_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        hold_next   = hold_reg;
        repeat_next = repeat_reg;
        gap_next    = gap_reg;
        ev.hit      = 1'b0;
        ev.code     = EV_DOWN;
        case (phase_reg)
            PH_DOWNCHK:
            begin
                if (same)
                begin
                    phase_next = PH_HELD;
                    ev.hit     = cfg.report_mask[MASK_DOWN];
                    ev.code    = EV_DOWN;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HELD:
            begin
                if (!same)
                begin
                    phase_next = PH_UPCHK;
                end
                else if (cfg.long_hold_time != '0)
                begin
                    hold_next = hold_sat;
                    if (CMP_BITS'(hold_sat) == CMP_BITS'(cfg.long_hold_time))
                    begin
                        ev.hit  = cfg.report_mask[MASK_LONG];
                        ev.code = EV_LONG;
                    end
                    else if (cfg.repeat_period != '0)
                    begin
                        if (CMP_BITS'(repeat_sat) >= CMP_BITS'(cfg.repeat_period))
                        begin
                            repeat_next = '0;
                            ev.hit      = cfg.report_mask[MASK_REPEAT];
                            ev.code     = EV_DOWN;
                        end
                        else
                        begin
                            repeat_next = repeat_sat;
                        end
                    end
                end
            end
            PH_UPCHK:
            begin
                if (same)
                begin
                    phase_next  = PH_RELEASED;
                    hold_next   = '0;
                    repeat_next = '0;
                    ev.hit      = cfg.report_mask[MASK_UP];
                    ev.code     = EV_UP;
                end
                else
                begin
                    phase_next = PH_HELD;
                end
            end
            PH_RELEASED:
            begin
                if ((CMP_BITS'(gap_reg) > CMP_BITS'(cfg.double_gap_min)) &&
                    (CMP_BITS'(gap_reg) < CMP_BITS'(cfg.double_gap_max)))
                begin
                    ev.hit  = cfg.report_mask[MASK_DOUBLE];
                    ev.code = EV_DOUBLE;
                end
                gap_next   = '0;
                phase_next = PH_IDLE;
            end
            default:
            begin
                // idle, and any code that cannot occur
                phase_next = pressed ? PH_DOWNCHK : PH_IDLE;
                gap_next   = gap_sat;
            end
        endcase
        if (!accept)
        begin
            ev.hit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            last_level_reg <= 1'b0;
            hold_reg       <= '0;
            repeat_reg     <= '0;
            gap_reg        <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            last_level_reg <= pressed;
            hold_reg       <= hold_next;
            repeat_reg     <= repeat_next;
            gap_reg        <= gap_next;
        end
    end

endmodule

[hdl/key_event_detector_top.sv]
// top level of the key event detector: register file, engine, output buffer
// depends on ked_pkg, ked_if (ked_in_if, ked_out_if) and ked_engine
//
// usage
//   key_in carries one sampled key level (pressed) per scan tick; a request is
//   taken at a rising edge where valid and ready are both high
//   event_out carries at most one event per sample: event_code (0 down or
//   repeat, 1 long press, 2 up, 3 double click) and key_id
//   settings are written over the apb-style port (register i at byte 4*i),
//   only while no sample is in flight (left to the user); pready is always high
// decode and throughput
//   a sample is decoded in the cycle it is taken; its event goes to the output
//   register, or to the skid buffer while event_out stalls, and on to event_out
//   one sample per cycle is sustained while the skid buffer is empty; the limit
//   is the single pass through the phase decode and a saturating add and compare per counter
// stall behavior
//   the output register plus a one-entry skid buffer let a new sample be
//   taken while an event waits; key_in.ready drops only while the skid
//   buffer holds an event
// reset
//   rst_n clears the phase machine, counters, buffers and settings to their
//   defaults (mask 31, long 1000, repeat 200, gap 50..300, step 10, key 0)

module key_event_detector_top #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ked_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [ked_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [ked_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    ked_in_if.sink                              key_in,
    ked_out_if.source                           event_out
);
    import ked_pkg::*;

    // settings registers
    ked_cfg_t     cfg_reg;
    ked_reg_idx_t reg_idx;
    logic         cfg_write;

    // sample handshake and engine result
    logic         accept;
    ked_event_t   ev;

    // output register and skid buffer
    logic         out_valid_reg;
    ked_code_t    out_code_reg;
    logic [7:0]   out_key_reg;
    logic         skid_valid_reg;
    ked_code_t    skid_code_reg;
    logic [7:0]   skid_key_reg;
    logic         out_free;

    assign pready    = 1'b1;
    assign reg_idx   = ked_reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.report_mask    <= RST_REPORT_MASK;
            cfg_reg.long_hold_time <= RST_LONG_HOLD_TIME;
            cfg_reg.repeat_period  <= RST_REPEAT_PERIOD;
            cfg_reg.double_gap_min <= RST_DOUBLE_GAP_MIN;
            cfg_reg.double_gap_max <= RST_DOUBLE_GAP_MAX;
            cfg_reg.tick_step      <= RST_TICK_STEP;
            cfg_reg.key_number     <= RST_KEY_NUMBER;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_REPORT_MASK:    cfg_reg.report_mask    <= pwdata[4:0];
                REG_LONG_HOLD_TIME: cfg_reg.long_hold_time <= pwdata[15:0];
                REG_REPEAT_PERIOD:  cfg_reg.repeat_period  <= pwdata[15:0];
                REG_DOUBLE_GAP_MIN: cfg_reg.double_gap_min <= pwdata[15:0];
                REG_DOUBLE_GAP_MAX: cfg_reg.double_gap_max <= pwdata[15:0];
                REG_TICK_STEP:      cfg_reg.tick_step      <= pwdata[7:0];
                REG_KEY_NUMBER:     cfg_reg.key_number     <= pwdata[7:0];
                default:            ;   // unmapped address, write dropped
            endcase
        end
    end

    // register read back, unused bits read as zero
    always_comb
    begin
        case (reg_idx)
            REG_REPORT_MASK:    prdata = APB_DATA_BITS'(cfg_reg.report_mask);
            REG_LONG_HOLD_TIME: prdata = APB_DATA_BITS'(cfg_reg.long_hold_time);
            REG_REPEAT_PERIOD:  prdata = APB_DATA_BITS'(cfg_reg.repeat_period);
            REG_DOUBLE_GAP_MIN: prdata = APB_DATA_BITS'(cfg_reg.double_gap_min);
            REG_DOUBLE_GAP_MAX: prdata = APB_DATA_BITS'(cfg_reg.double_gap_max);
            REG_TICK_STEP:      prdata = APB_DATA_BITS'(cfg_reg.tick_step);
            REG_KEY_NUMBER:     prdata = APB_DATA_BITS'(cfg_reg.key_number);
            default:            prdata = '0;
        endcase
    end

    // a sample is taken whenever the skid buffer has room
    assign key_in.ready = !skid_valid_reg;
    assign accept       = key_in.valid && key_in.ready;

    ked_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .pressed (key_in.pressed),
        .cfg     (cfg_reg),
        .ev      (ev)
    );

    // output register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || event_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= ev.hit;
            end
        end
        else if (ev.hit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_code_reg <= skid_code_reg;
                out_key_reg  <= skid_key_reg;
            end
            else
            begin
                out_code_reg <= ev.code;
                out_key_reg  <= cfg_reg.key_number;
            end
        end
        else if (ev.hit)
        begin
            skid_code_reg <= ev.code;
            skid_key_reg  <= cfg_reg.key_number;
        end
    end

    assign event_out.valid      = out_valid_reg;
    assign event_out.event_code = out_code_reg;
    assign event_out.key_id     = out_key_reg;

endmodule
